@@ rtl/core/hufd_pkg.sv @@
package hufd_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_DECODE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int SYM_W = 8;

    typedef struct packed {
        logic             done;
        logic             symbol_valid;
        logic [SYM_W-1:0] decoded_symbol;
        logic [1:0]       status;
    } res_t;

endpackage

@@ rtl/core/hufd_req_if.sv @@
interface hufd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic        stream_bit;

    modport source (
        output valid, func, symbol, code_bits, code_length, stream_bit,
        input  ready
    );

    modport sink (
        input  valid, func, symbol, code_bits, code_length, stream_bit,
        output ready
    );
endinterface

@@ rtl/core/hufd_rsp_if.sv @@
interface hufd_rsp_if;
    logic       valid;
    logic       ready;
    logic       symbol_valid;
    logic [7:0] decoded_symbol;
    logic [1:0] status;

    modport source (
        output valid, symbol_valid, decoded_symbol, status,
        input  ready
    );

    modport sink (
        input  valid, symbol_valid, decoded_symbol, status,
        output ready
    );
endinterface

@@ rtl/core/huffman_trie_decoder_unit.sv @@
// Huffman code trie decoder. Each request is a load of one code-table entry, one
// decode bit, or a clear, and each request gives exactly one response. Node
// words (left child, right child, symbol) live in one single-port-write RAM
// with a registered read, and every step of a load or decode goes through that
// RAM, so requests are handled one at a time. A decode bit reads the current
// node in S_DC_CUR and then the chosen child in S_DC_CHILD, or skips the child
// read when the branch is missing. A load walks the code bits in S_LD_STEP and
// passes through S_LD_NEW for each bit that allocates a new node. A clear or an
// unused function code goes straight to S_RESULT. After reset the block writes
// the root in S_INIT before it takes its first request; a clear resets the node
// count, root and decode cursor only, since nodes beyond the count are never read.
module huffman_trie_decoder_unit #(
    parameter int MAX_NODES    = 512,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    hufd_req_if.sink    req,
    hufd_rsp_if.source  rsp
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int ENTRY_W = 2 * NODE_W + hufd_pkg::SYM_W;

    hufd_pkg::res_t         res;
    logic                   out_free;
    logic                   wr_en;
    logic [NODE_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en;
    logic [NODE_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]     rd_data;

    logic                   out_valid_reg;
    logic                   out_symbol_valid_reg;
    logic [7:0]             out_symbol_reg;
    logic [1:0]             out_status_reg;

    hufd_ctrl #(
        .MAX_NODES    (MAX_NODES),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    hufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            out_symbol_valid_reg <= res.symbol_valid;
            out_symbol_reg       <= res.decoded_symbol;
            out_status_reg       <= res.status;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.symbol_valid   = out_symbol_valid_reg;
    assign rsp.decoded_symbol = out_symbol_reg;
    assign rsp.status         = out_status_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while a request was in progress");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> (!rsp.valid || rsp.ready))
        else $error("response overwrote one not yet taken");

    a_symbol_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.symbol_valid |-> rsp.status == hufd_pkg::ST_OK)
        else $error("decoded symbol reported with an error status");

    a_no_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.symbol_valid |-> rsp.decoded_symbol == 8'd0)
        else $error("symbol field not zero without a decoded symbol");
`endif

endmodule

@@ rtl/core/hufd_ram.sv @@
module hufd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/hufd_ctrl.sv @@
module hufd_ctrl #(
    parameter int MAX_NODES    = 512,
    parameter int MAX_CODE_LEN = 16,
    localparam int NODE_W  = $clog2(MAX_NODES),
    localparam int ENTRY_W = 2 * NODE_W + hufd_pkg::SYM_W
) (
    input  logic                clk,
    input  logic                rst_n,
    hufd_req_if.sink            req,
    input  logic                out_free,
    output hufd_pkg::res_t      res,
    output logic                wr_en,
    output logic [NODE_W-1:0]   wr_addr,
    output logic [ENTRY_W-1:0]  wr_data,
    output logic                rd_en,
    output logic [NODE_W-1:0]   rd_addr,
    input  logic [ENTRY_W-1:0]  rd_data
);

    localparam int USED_W     = $clog2(MAX_NODES + 1);
    localparam int IDX_W      = (MAX_CODE_LEN > 16) ? 5 : 4;
    localparam int CODE_EXT_W = 1 << IDX_W;
    localparam int CNT_W      = IDX_W + 1;
    localparam int SYM_W      = hufd_pkg::SYM_W;

    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_LD_STEP  = 9'b000000100,
        S_LD_NEW   = 9'b000001000,
        S_DC_CUR   = 9'b000010000,
        S_DC_CHILD = 9'b000100000,
        S_RESULT   = 9'b001000000,
        S_SPARE_A  = 9'b010000000,
        S_SPARE_B  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [NODE_W-1:0]      cur_reg, cur_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W-1:0]      child_reg, child_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CODE_EXT_W-1:0]  code_reg, code_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic                   bit_reg, bit_next;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;
    logic                   fresh_reg, fresh_next;
    logic                   rvalid_reg, rvalid_next;
    logic [SYM_W-1:0]       rsym_reg, rsym_next;
    logic [1:0]             rstat_reg, rstat_next;

    logic [ENTRY_W-1:0]     entry;
    logic [NODE_W-1:0]      ent_left;
    logic [NODE_W-1:0]      ent_right;
    logic [SYM_W-1:0]       ent_sym;
    logic [CNT_W-1:0]       cnt_dec;
    logic                   code_bit;
    logic [NODE_W-1:0]      ld_child;
    logic [NODE_W-1:0]      dc_child;
    logic [5:0]             len_ext;
    logic [CNT_W-1:0]       len_cap;
    logic                   pool_full;

    assign entry     = fresh_reg ? rd_data : entry_reg;
    assign ent_left  = entry[ENTRY_W-1 -: NODE_W];
    assign ent_right = entry[SYM_W +: NODE_W];
    assign ent_sym   = entry[SYM_W-1:0];
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign code_bit  = code_reg[cnt_dec[IDX_W-1:0]];
    assign ld_child  = code_bit ? ent_right : ent_left;
    assign dc_child  = bit_reg ? ent_right : ent_left;
    assign len_ext   = 6'(req.code_length);
    assign len_cap   = (len_ext > 6'(MAX_CODE_LEN)) ? CNT_W'(MAX_CODE_LEN)
                                                     : CNT_W'(req.code_length);
    assign pool_full = (used_reg == USED_W'(MAX_NODES));

    assign req.ready = (state_reg == S_IDLE);

    assign res.done           = (state_reg == S_RESULT) && out_free;
    assign res.symbol_valid   = rvalid_reg;
    assign res.decoded_symbol = rsym_reg;
    assign res.status         = rstat_reg;

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        cur_next    = cur_reg;
        node_next   = node_reg;
        child_next  = child_reg;
        cnt_next    = cnt_reg;
        code_next   = code_reg;
        sym_next    = sym_reg;
        bit_next    = bit_reg;
        entry_next  = entry_reg;
        fresh_next  = fresh_reg;
        rvalid_next = rvalid_reg;
        rsym_next   = rsym_reg;
        rstat_next  = rstat_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rvalid_next = 1'b0;
                    rsym_next   = '0;
                    rstat_next  = hufd_pkg::ST_OK;
                    case (req.func)
                        hufd_pkg::FUNC_LOAD:
                        begin
                            node_next  = '0;
                            cnt_next   = len_cap;
                            code_next  = CODE_EXT_W'(req.code_bits);
                            sym_next   = req.symbol;
                            rd_en      = 1'b1;
                            fresh_next = 1'b1;
                            state_next = S_LD_STEP;
                        end
                        hufd_pkg::FUNC_DECODE:
                        begin
                            bit_next   = req.stream_bit;
                            rd_en      = 1'b1;
                            rd_addr    = cur_reg;
                            fresh_next = 1'b1;
                            state_next = S_DC_CUR;
                        end
                        hufd_pkg::FUNC_CLEAR:
                        begin
                            wr_en      = 1'b1;
                            used_next  = USED_W'(1);
                            cur_next   = '0;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_LD_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = node_reg;
                    wr_data    = {ent_left, ent_right, sym_reg};
                    state_next = S_RESULT;
                end
                else if (ld_child != '0)
                begin
                    node_next  = ld_child;
                    cnt_next   = cnt_dec;
                    rd_en      = 1'b1;
                    rd_addr    = ld_child;
                    fresh_next = 1'b1;
                end
                else if (pool_full)
                begin
                    rstat_next = hufd_pkg::ST_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = node_reg;
                    if (code_bit)
                    begin
                        wr_data = {ent_left, used_reg[NODE_W-1:0], ent_sym};
                    end
                    else
                    begin
                        wr_data = {used_reg[NODE_W-1:0], ent_right, ent_sym};
                    end
                    state_next = S_LD_NEW;
                end
            end
            S_LD_NEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = used_reg[NODE_W-1:0];
                node_next  = used_reg[NODE_W-1:0];
                used_next  = used_reg + USED_W'(1);
                cnt_next   = cnt_dec;
                entry_next = '0;
                fresh_next = 1'b0;
                state_next = S_LD_STEP;
            end
            S_DC_CUR:
            begin
                if (dc_child == '0)
                begin
                    rstat_next = hufd_pkg::ST_MISSING;
                    cur_next   = '0;
                    state_next = S_RESULT;
                end
                else
                begin
                    child_next = dc_child;
                    rd_en      = 1'b1;
                    rd_addr    = dc_child;
                    state_next = S_DC_CHILD;
                end
            end
            S_DC_CHILD:
            begin
                if ((ent_left == '0) && (ent_right == '0))
                begin
                    rvalid_next = 1'b1;
                    rsym_next   = ent_sym;
                    cur_next    = '0;
                end
                else
                begin
                    cur_next = child_reg;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            used_reg  <= USED_W'(1);
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        child_reg  <= child_next;
        cnt_reg    <= cnt_next;
        code_reg   <= code_next;
        sym_reg    <= sym_next;
        bit_reg    <= bit_next;
        entry_reg  <= entry_next;
        fresh_reg  <= fresh_next;
        rvalid_reg <= rvalid_next;
        rsym_reg   <= rsym_next;
        rstat_reg  <= rstat_next;
    end

endmodule

@@ sim/hufd_trie_checker.sv @@
`timescale 1ns / 100ps

module hufd_trie_checker #(
    parameter int NODES    = 512,
    parameter int CODE_MAX = 16
) (
    input  logic clk,
    input  logic rst_n,
    hufd_req_if  req,
    hufd_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic       symbol_valid;
        logic [7:0] decoded_symbol;
        logic [1:0] status;
    } hufd_answer_t;

    logic [8:0] left_kid  [0:NODES-1];
    logic [8:0] right_kid [0:NODES-1];
    logic [7:0] leaf_sym  [0:NODES-1];
    logic [9:0] node_count;
    logic [8:0] cursor;

    hufd_answer_t pending_answers[$];
    hufd_answer_t want;
    hufd_answer_t fresh;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic wipe_trie();
        for (int i = 0; i < NODES; i++)
        begin
            left_kid[i]  = '0;
            right_kid[i] = '0;
            leaf_sym[i]  = '0;
        end
        node_count = 10'd1;
        cursor     = '0;
    endtask

    // Walks the code from its first bit and takes fresh nodes from the pool as needed.
    task automatic insert_code(input logic [7:0] sym, input logic [15:0] bits,
                               input logic [4:0] len, output logic [1:0] st);
        logic [8:0] node;
        logic [8:0] next;
        logic       b;
        int         steps;
        node  = '0;
        st    = hufd_pkg::ST_OK;
        steps = (int'(len) > CODE_MAX) ? CODE_MAX : int'(len);
        for (int i = steps; i > 0; i--)
        begin
            b    = bits[i-1];
            next = b ? right_kid[node] : left_kid[node];
            if (next == '0)
            begin
                if (int'(node_count) >= NODES)
                begin
                    st = hufd_pkg::ST_FULL;
                    return;
                end
                next = node_count[8:0];
                node_count++;
                left_kid[next]  = '0;
                right_kid[next] = '0;
                leaf_sym[next]  = '0;
                if (b)
                    right_kid[node] = next;
                else
                    left_kid[node] = next;
            end
            node = next;
        end
        leaf_sym[node] = sym;
    endtask

    task automatic trie_answer(input logic [1:0] f, input logic [7:0] sym,
                               input logic [15:0] bits, input logic [4:0] len,
                               input logic sbit, output hufd_answer_t ans);
        logic [1:0] st;
        logic [8:0] next;
        ans = '0;
        case (f)
            hufd_pkg::FUNC_LOAD:
            begin
                insert_code(sym, bits, len, st);
                ans.status = st;
            end
            hufd_pkg::FUNC_DECODE:
            begin
                next = sbit ? right_kid[cursor] : left_kid[cursor];
                if (next == '0)
                begin
                    ans.status = hufd_pkg::ST_MISSING;
                    cursor     = '0;
                end
                else if (left_kid[next] == '0 && right_kid[next] == '0)
                begin
                    ans.symbol_valid   = 1'b1;
                    ans.decoded_symbol = leaf_sym[next];
                    cursor             = '0;
                end
                else
                    cursor = next;
            end
            hufd_pkg::FUNC_CLEAR:
                wipe_trie();
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_trie();
            pending_answers.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch($sformatf("response with no request outstanding: %b %h %h",
                                              rsp.symbol_valid, rsp.decoded_symbol, rsp.status));
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.symbol_valid !== want.symbol_valid)
                        report_mismatch($sformatf("symbol_valid %b, expected %b",
                                                  rsp.symbol_valid, want.symbol_valid));
                    if (rsp.decoded_symbol !== want.decoded_symbol)
                        report_mismatch($sformatf("decoded_symbol %h, expected %h",
                                                  rsp.decoded_symbol, want.decoded_symbol));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %h, expected %h",
                                                  rsp.status, want.status));
                end
            end
            if (req.valid && req.ready)
            begin
                trie_answer(req.func, req.symbol, req.code_bits, req.code_length,
                            req.stream_bit, fresh);
                pending_answers.push_back(fresh);
            end
        end
        pending = pending_answers.size();
    end

endmodule

@@ sim/tb_huffman_trie_decoder_unit.sv @@
`timescale 1ns / 100ps

module tb_huffman_trie_decoder_unit;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_TARGET = 1800;
    localparam int CALM_TAIL    = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    logic clk;
    logic rst_n;

    hufd_req_if req_ch();
    hufd_rsp_if rsp_ch();

    int fail_count;
    int pending;

    huffman_trie_decoder_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    hufd_trie_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    bit idle_on;
    int idle_pct;
    bit hold_request;
    int stall_cycles;

    int sent;
    int n_loads;
    int n_decodes;
    int n_clears;
    int n_unused;
    int n_tables;

    logic [15:0] word_bits[$];
    logic [4:0]  word_len[$];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d responses outstanding.", pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Response side: short random stalls, or one long hold-off when asked for.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic send_req(input logic [1:0] f, input logic [7:0] sym,
                            input logic [15:0] bits, input logic [4:0] len,
                            input logic sbit);
        if (sent >= ITEMS_TARGET - CALM_TAIL)
            idle_on = 1'b0;
        if (idle_on && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.symbol      <= sym;
        req_ch.code_bits   <= bits;
        req_ch.code_length <= len;
        req_ch.stream_bit  <= sbit;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
        case (f)
            hufd_pkg::FUNC_LOAD:   n_loads++;
            hufd_pkg::FUNC_DECODE: n_decodes++;
            hufd_pkg::FUNC_CLEAR:  n_clears++;
            default:               n_unused++;
        endcase
    endtask

    task automatic send_load(input logic [7:0] sym, input logic [15:0] bits,
                             input logic [4:0] len);
        send_req(hufd_pkg::FUNC_LOAD, sym, bits, len, 1'($urandom));
    endtask

    task automatic send_decode(input logic sbit);
        send_req(hufd_pkg::FUNC_DECODE, 8'($urandom), 16'($urandom), 5'($urandom), sbit);
    endtask

    task automatic send_clear();
        send_req(hufd_pkg::FUNC_CLEAR, 8'($urandom), 16'($urandom), 5'($urandom),
                 1'($urandom));
    endtask

    task automatic send_unused();
        send_req(FUNC_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic send_random_load();
        send_load(8'($urandom), 16'($urandom), 5'($urandom_range(0, 31)));
    endtask

    task automatic drain_all();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Grows a prefix-free code by splitting random leaves of a tree.
    task automatic build_code_table(input int leaves, input int depth_cap);
        int          pick;
        int          tries;
        logic [15:0] b;
        logic [4:0]  l;
        word_bits = {16'd0};
        word_len  = {5'd0};
        tries     = 0;
        while (word_len.size() < leaves && tries < 1000)
        begin
            tries++;
            pick = $urandom_range(0, word_len.size() - 1);
            if (int'(word_len[pick]) < depth_cap)
            begin
                b = word_bits[pick];
                l = word_len[pick];
                word_bits.delete(pick);
                word_len.delete(pick);
                word_bits.push_back({b[14:0], 1'b0});
                word_len.push_back(5'(l + 1));
                word_bits.push_back({b[14:0], 1'b1});
                word_len.push_back(5'(l + 1));
            end
        end
    endtask

    task automatic fill_node_pool();
        send_clear();
        repeat (60)
        begin
            if ($urandom_range(0, 5) == 0)
                send_load(8'($urandom), 16'($urandom), 5'($urandom_range(17, 31)));
            else
                send_load(8'($urandom), 16'($urandom), 5'd16);
        end
        repeat (20)
            send_decode(1'($urandom));
        send_clear();
    endtask

    initial
    begin
        int  pick;
        int  r;
        int  words;
        bit  hold_done;
        bit  pool_done;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= hufd_pkg::FUNC_LOAD;
        req_ch.symbol      <= '0;
        req_ch.code_bits   <= '0;
        req_ch.code_length <= '0;
        req_ch.stream_bit  <= 1'b0;
        idle_on      = 1'b1;
        idle_pct     = 20;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pool_done    = 1'b0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_decode(1'b0);
        send_decode(1'b1);
        send_req(FUNC_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 1'b1);
        send_load(8'hA5, 16'h0000, 5'd0);
        send_load(8'h00, 16'h0000, 5'd1);
        send_load(8'hFF, 16'h0001, 5'd1);
        send_decode(1'b0);
        send_decode(1'b1);
        send_load(8'h3C, 16'h0001, 5'd1);
        send_decode(1'b1);
        send_load(8'h5A, 16'h0002, 5'd2);
        send_decode(1'b1);
        send_decode(1'b0);
        send_decode(1'b1);
        send_decode(1'b1);
        send_decode(1'b1);
        send_load(8'h77, 16'h0003, 5'd2);
        send_decode(1'b1);
        send_load(8'h81, 16'hFFFF, 5'd31);
        send_load(8'h42, 16'h0000, 5'd16);
        send_decode(1'b0);
        send_clear();
        send_decode(1'b0);
        drain_all();

        while (sent < ITEMS_TARGET)
        begin
            if (sent >= ITEMS_TARGET - CALM_TAIL)
                idle_on = 1'b0;
            if (!hold_done && sent >= 400)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pool_done && sent >= 700)
            begin
                drain_all();
                fill_node_pool();
                pool_done = 1'b1;
            end
            n_tables++;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if ($urandom_range(0, 4) != 0)
                send_clear();
            build_code_table($urandom_range(2, 40),
                             ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8));
            for (int k = 0; k < word_len.size(); k++)
                send_load(8'($urandom), word_bits[k], word_len[k]);
            words = $urandom_range(20, 60);
            for (int w = 0; w < words; w++)
            begin
                if (sent >= ITEMS_TARGET)
                    break;
                r = $urandom_range(0, 199);
                if (r < 8)
                    send_decode(1'($urandom));
                else if (r < 14)
                    send_random_load();
                else if (r < 16)
                    send_unused();
                else if (r < 17)
                    send_clear();
                else
                begin
                    pick = $urandom_range(0, word_len.size() - 1);
                    for (int i = int'(word_len[pick]); i > 0; i--)
                        send_decode(word_bits[pick][i-1]);
                end
            end
        end

        drain_all();
        repeat (20) @(posedge clk);
        $display("Run covered %0d requests: %0d loads, %0d decode bits, %0d clears, %0d unused.",
                 sent, n_loads, n_decodes, n_clears, n_unused);
        $display("It decoded %0d random code tables, filled the node pool once and held off %0d cycles.",
                 n_tables, HOLD_CYCLES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
